@@ hdl/sqi_pkg.sv @@
`timescale 1ns / 1ps
package sqi_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int PAY_W    = 16;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // register word index, taken from paddr bit 2
  localparam logic REG_ORDER_ASCENDING = 1'b0;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]  out_payload;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic    insert;
    logic    pop;
    logic    ascending;
    entry_t  fresh;
  } cmd_t;

endpackage

@@ hdl/sqi_in_if.sv @@
`timescale 1ns / 1ps
interface sqi_in_if;
  logic              valid;
  logic              ready;
  sqi_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sqi_out_if.sv @@
`timescale 1ns / 1ps
interface sqi_out_if;
  logic               valid;
  logic               ready;
  sqi_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sqi_cell.sv @@
`timescale 1ns / 1ps
module sqi_cell (
  input  logic            clk,
  input  sqi_pkg::cmd_t   cmd,
  input  logic            slot_valid,
  input  logic            slot_tail,
  input  logic            left_move,
  input  sqi_pkg::entry_t left_entry,
  input  sqi_pkg::entry_t right_entry,
  input  logic            right_all,
  output logic            all_out,
  output logic            move_out,
  output sqi_pkg::entry_t entry_out
);

  sqi_pkg::entry_t entry_r;
  sqi_pkg::entry_t entry_nxt;
  logic            fresh_first;

  // fresh key must leave strictly before the stored one
  assign fresh_first = cmd.ascending ? (cmd.fresh.key < entry_r.key)
                                     : (cmd.fresh.key > entry_r.key);

  // every occupied slot from here to the tail steps aside
  assign all_out  = (slot_valid ? fresh_first : 1'b1) & right_all;
  assign move_out = slot_valid & all_out;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.insert) begin
      if (left_move) begin
        entry_nxt = left_entry;
      end else if (move_out || slot_tail) begin
        entry_nxt = cmd.fresh;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule

@@ hdl/sorted_insert_queue.sv @@
`timescale 1ns / 1ps
// Sorted insertion queue of sqi_pkg::CAPACITY entries, each an 8-bit key with a
// 16-bit handle. A request either inserts an entry or pops the head; every
// request yields exactly one result carrying the popped entry (if any), a
// drop flag for an insert into a full queue, and the occupancy afterwards.
// Equal keys leave first in, first out. The entries sit in a row of cells,
// head at cell 0; on an insert every cell compares the new key with its own
// and the cells at and past the insertion point move one step towards the
// tail, on a pop every cell takes its right neighbour's entry. One request
// is taken per clock and its result appears in the output register on the
// next cycle; a request is taken while a result waits as long as the sink
// takes it in the same cycle. The clock is set by the step-aside chain that
// runs from the tail cell to the head cell through one key compare per cell.
// The order register (address 0, bit 0, reset 1 = smallest key first) is
// not re-applied to stored entries; change it only while the queue is idle.
module sorted_insert_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  sqi_in_if.sink                         in_ch,
  sqi_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sqi_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [sqi_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [sqi_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CAP   = sqi_pkg::CAPACITY;
  localparam int CNT_W = sqi_pkg::CNT_W;

  // configuration
  logic ascending_r;
  logic cfg_write;

  // queue control
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             accept;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_pop;
  sqi_pkg::cmd_t    cmd;

  // cell row
  sqi_pkg::entry_t  entry_q [CAP];
  logic             all_w   [CAP+1];
  logic             move_w  [CAP];

  // result register
  logic               out_valid_r;
  sqi_pkg::out_item_t out_data_r;
  sqi_pkg::out_item_t result;

  // ---------------------------------------------------------------------
  // APB register: write on the access phase, reads are combinational
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascending_r <= 1'b1;
    end else if (cfg_write && cfg_paddr[2] == sqi_pkg::REG_ORDER_ASCENDING) begin
      ascending_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == sqi_pkg::REG_ORDER_ASCENDING) begin
      cfg_prdata[0] = ascending_r;
    end
  end

  // ---------------------------------------------------------------------
  // Request decode: drop inserts into a full queue, ignore pops when empty
  // ---------------------------------------------------------------------
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_pop      = (in_ch.data.kind == sqi_pkg::KIND_POP);
  assign full        = (count_r == CNT_W'(CAP));
  assign empty       = (count_r == '0);
  assign do_insert   = accept & ~is_pop & ~full;
  assign do_pop      = accept & is_pop & ~empty;

  always_comb begin
    cmd.insert        = do_insert;
    cmd.pop           = do_pop;
    cmd.ascending     = ascending_r;
    cmd.fresh.key     = in_ch.data.key;
    cmd.fresh.payload = in_ch.data.payload;
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: head at index 0, the step-aside chain enters from the tail
  // ---------------------------------------------------------------------
  assign all_w[CAP] = 1'b1;

  for (genvar j = 0; j < CAP; j++) begin : g_cell
    logic            slot_valid;
    logic            slot_tail;
    logic            left_move;
    sqi_pkg::entry_t left_entry;
    sqi_pkg::entry_t right_entry;

    assign slot_valid = (count_r > CNT_W'(j));
    assign slot_tail  = (count_r == CNT_W'(j));

    if (j == 0) begin : g_head
      assign left_move  = 1'b0;
      assign left_entry = cmd.fresh;
    end else begin : g_body
      assign left_move  = move_w[j-1];
      assign left_entry = entry_q[j-1];
    end

    if (j == CAP - 1) begin : g_tail
      assign right_entry = entry_q[j];
    end else begin : g_inner
      assign right_entry = entry_q[j+1];
    end

    sqi_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .slot_valid  (slot_valid),
      .slot_tail   (slot_tail),
      .left_move   (left_move),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_all   (all_w[j+1]),
      .all_out     (all_w[j]),
      .move_out    (move_w[j]),
      .entry_out   (entry_q[j])
    );
  end

  // ---------------------------------------------------------------------
  // Result: head entry on a pop, drop flag, occupancy after the request
  // ---------------------------------------------------------------------
  always_comb begin
    result.out_valid   = do_pop;
    result.out_key     = do_pop ? entry_q[0].key : '0;
    result.out_payload = do_pop ? entry_q[0].payload : '0;
    result.dropped     = accept & ~is_pop & full;
    result.occupancy   = sqi_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAP))
    else $error("occupancy beyond capacity");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not release one entry");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pop && full) |=> out_valid_r && out_data_r.dropped
      && count_r == CNT_W'(CAP))
    else $error("insert into full queue not dropped");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.out_valid && out_data_r.dropped))
    else $error("result both popped and dropped");

endmodule

@@ tb/sorted_insert_queue_tb.sv @@
`timescale 1ns / 1ps
module sorted_insert_queue_tb;
  import sqi_pkg::*;

  localparam int TARGET_REQUESTS = 1850;
  localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES     = 64;    // long output stall, well past one result slot
  localparam int REPORT_LIMIT    = 10;
  localparam int INSERT_MIX [5]  = '{90, 60, 50, 35, 12};

  // register byte addresses; the spare word exercises an ignored write
  localparam logic [CFG_AW-1:0] ORDER_ADDR    = {REG_ORDER_ASCENDING, 2'b00};
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = {~REG_ORDER_ASCENDING, 2'b00};

  typedef enum int {KEYS_FULL, KEYS_TIED, KEYS_EDGE} key_spread_t;

  logic clk;
  logic rst_n = 1'b0;

  // request side and result side, driven from local registers so every input
  // of the block is known from the first instant
  sqi_in_if  req_if ();
  sqi_out_if res_if ();
  logic      req_valid = 1'b0;
  in_item_t  req_data  = '0;
  logic      res_ready = 1'b0;

  assign req_if.valid = req_valid;
  assign req_if.data  = req_data;
  assign res_if.ready = res_ready;

  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sorted_insert_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_if),
    .out_ch      (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the queue: entries held head first, plus our copy of the order bit
  // ---------------------------------------------------------------------------
  entry_t      stored [CAPACITY];
  int          stored_count = 0;
  logic        order_asc    = 1'b1;

  in_item_t    requests_waiting [$];  // stimulus not yet offered to the block
  out_item_t   results_due [$];       // predicted results, oldest first

  // bookkeeping for the summary and the verdict
  int inserts = 0, pops = 0, drops = 0, empty_pops = 0, returned = 0, peak_occ = 0;
  int results_checked = 0, order_writes = 0, holds = 0, queued = 0;
  int error_count = 0, reported = 0;

  // idling controls, set by the sequencer at the falling edge
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   hold_trigger = 0;

  // a fresh key overtakes a stored one only when strictly better, so ties stay FIFO
  function automatic bit goes_ahead(logic [KEY_W-1:0] fresh, logic [KEY_W-1:0] held);
    return order_asc ? (fresh < held) : (fresh > held);
  endfunction

  // Apply one request to the shadow and return the result it must produce.
  function automatic out_item_t step_sorted_queue(in_item_t req);
    out_item_t res;
    int        pos;
    res = '0;
    if (req.kind == KIND_INSERT) begin
      inserts++;
      if (stored_count >= CAPACITY) begin
        // full: drop the newcomer, leave the stored entries untouched
        res.dropped = 1'b1;
        drops++;
      end else begin
        // walk from the tail, sliding entries back until the slot is found
        pos = stored_count;
        while (pos > 0 && goes_ahead(req.key, stored[pos-1].key)) begin
          stored[pos] = stored[pos-1];
          pos--;
        end
        stored[pos].key     = req.key;
        stored[pos].payload = req.payload;
        stored_count++;
      end
    end else begin
      pops++;
      if (stored_count == 0) begin
        // empty: nothing returned, all-zero entry fields
        empty_pops++;
      end else begin
        res.out_valid   = 1'b1;
        res.out_key     = stored[0].key;
        res.out_payload = stored[0].payload;
        for (pos = 1; pos < stored_count; pos++) stored[pos-1] = stored[pos];
        stored_count--;
        returned++;
      end
    end
    res.occupancy = OCC_W'(stored_count);
    if (stored_count > peak_occ) peak_occ = stored_count;
    return res;
  endfunction

  function automatic void note_error();
    error_count++;
    reported++;
  endfunction

  // Compare one result taken from the block against the oldest prediction.
  function automatic void check_result(out_item_t got);
    out_item_t want;
    results_checked++;
    if (results_due.size() == 0) begin
      if (reported < REPORT_LIMIT)
        $display("%0t: result with nothing outstanding: valid=%0d key=%02h pay=%04h drop=%0d occ=%0d",
                 $time, got.out_valid, got.out_key, got.out_payload, got.dropped, got.occupancy);
      note_error();
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        if (reported < REPORT_LIMIT) begin
          $display("%0t: result mismatch", $time);
          $display("  expected valid=%0d key=%02h pay=%04h drop=%0d occ=%0d",
                   want.out_valid, want.out_key, want.out_payload, want.dropped, want.occupancy);
          $display("  actual   valid=%0d key=%02h pay=%04h drop=%0d occ=%0d",
                   got.out_valid, got.out_key, got.out_payload, got.dropped, got.occupancy);
        end
        note_error();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer the next waiting request, hold it until taken,
  // then idle for a drawn number of cycles
  // ---------------------------------------------------------------------------
  int send_wait = 0;

  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      req_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_valid && req_if.ready) results_due.push_back(step_sorted_queue(req_data));
      if (!req_valid || req_if.ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          req_valid <= 1'b0;
        end else if (requests_waiting.size() > 0) begin
          req_data  <= requests_waiting.pop_front();
          req_valid <= 1'b1;
          send_wait <= tx_steady ? 0 : $urandom_range(0, 4);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check every result taken, stall ready per result, and
  // run a long hold-off whenever the sequencer asks for one
  // ---------------------------------------------------------------------------
  int rx_wait   = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin : result_monitor
    int draw;
    if (!rst_n) begin
      res_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
      hold_seen <= hold_trigger;
    end else begin
      if (res_if.valid && res_ready) check_result(res_if.data);
      if (hold_trigger != hold_seen) begin
        // start the long stall: the block fills its output slot and backs up
        hold_seen <= hold_trigger;
        hold_left <= HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (res_if.valid && res_ready) begin
        draw = rx_steady ? 0 : $urandom_range(0, 4);
        rx_wait   <= draw;
        res_ready <= (draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait   <= rx_wait - 1;
        res_ready <= (rx_wait == 1);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up when no handshake of any kind happens for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_psel || (req_valid && req_if.ready) || (res_if.valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, results_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(kind_t kind, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload);
    in_item_t r;
    r.kind    = kind;
    r.key     = key;
    r.payload = payload;
    requests_waiting.push_back(r);
    queued++;
  endtask

  function automatic in_item_t random_request(int insert_pct, key_spread_t spread);
    in_item_t r;
    r.kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_POP;
    case (spread)
      KEYS_TIED: r.key = KEY_W'($urandom_range(3));
      KEYS_EDGE: r.key = $urandom_range(1) ? KEY_W'($urandom_range(1)) : ~KEY_W'($urandom_range(1));
      default:   r.key = KEY_W'($urandom);
    endcase
    r.payload = PAY_W'($urandom);  // also filled on pops, where it must be ignored
    return r;
  endfunction

  // wait until every request has been offered, taken and answered
  task automatic settle();
    while (requests_waiting.size() != 0 || req_valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic apb_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ORDER_ADDR) begin
      order_asc = value[0];
      order_writes++;
    end
  endtask

  // read the order register back and compare with our copy
  task automatic apb_check_order();
    logic [CFG_DW-1:0] seen;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ORDER_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    seen = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (seen !== CFG_DW'(order_asc)) begin
      if (reported < REPORT_LIMIT)
        $display("%0t: order register read back %08h, expected %08h",
                 $time, seen, CFG_DW'(order_asc));
      note_error();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int                phase;
    int                phase_len;
    logic [CFG_DW-1:0] word;
    key_spread_t       spread;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the order bit
    apb_check_order();
    @(negedge clk);

    // Ascending after reset: pop on an empty queue, both key extremes, ties on
    // a middle and on the lowest key, then drain past empty.
    queue_request(KIND_POP,    8'h3C, 16'h0F0F);
    queue_request(KIND_INSERT, 8'h80, 16'hA5A5);
    queue_request(KIND_INSERT, 8'hFF, 16'hFFFF);
    queue_request(KIND_INSERT, 8'h00, 16'h0000);
    queue_request(KIND_INSERT, 8'h80, 16'h5A5A);
    queue_request(KIND_INSERT, 8'h00, 16'h0001);
    repeat (6) queue_request(KIND_POP, 8'hFF, 16'hFFFF);

    // Descending while empty; a write to the spare word must change nothing.
    settle();
    apb_write(ORDER_ADDR, '0);
    apb_write(UNMAPPED_ADDR, '1);
    apb_check_order();
    @(negedge clk);
    queue_request(KIND_INSERT, 8'h10, 16'h0001);
    queue_request(KIND_INSERT, 8'hFF, 16'h0002);
    queue_request(KIND_INSERT, 8'h10, 16'h0003);
    queue_request(KIND_INSERT, 8'h00, 16'h0004);
    repeat (2) queue_request(KIND_POP, 8'h00, 16'h0000);

    // Flip back to ascending with two entries held: they keep their order and
    // the newcomer is placed by scanning from the tail under the new order.
    settle();
    apb_write(ORDER_ADDR, CFG_DW'(1));
    apb_check_order();
    @(negedge clk);
    queue_request(KIND_INSERT, 8'h05, 16'h0005);
    repeat (4) queue_request(KIND_POP, 8'h00, 16'h0000);

    // Random phases: each picks an order, an insert/pop mix and a key spread.
    // Insert-heavy mixes drive the queue full, pop-heavy ones drain it dry,
    // tight key spreads force ties.
    phase = 0;
    while (queued < TARGET_REQUESTS) begin
      settle();
      word = $urandom;
      case (phase % 4)
        0:       word[0] = 1'b1;
        1:       word[0] = 1'b0;
        default: word[0] = 1'($urandom_range(1));
      endcase
      apb_write(ORDER_ADDR, word);
      if (phase % 3 == 2) apb_write(UNMAPPED_ADDR, $urandom);
      apb_check_order();
      @(negedge clk);

      // some phases run flat out on both sides, others only on one
      tx_steady = (phase % 4 == 2);
      rx_steady = (phase % 4 == 2) || (phase % 7 == 5);

      phase_len = $urandom_range(50, 110);
      spread    = key_spread_t'($urandom_range(2));
      repeat (phase_len) begin
        requests_waiting.push_back(random_request(INSERT_MIX[phase % 5], spread));
        queued++;
      end

      // hold the result side off while the requests keep coming
      if (phase % 6 == 3) begin
        hold_trigger++;
        holds++;
      end
      phase++;
    end

    settle();
    repeat (4) @(posedge clk);

    if (results_due.size() != 0) begin
      $display("%0d predicted results never arrived", results_due.size());
      error_count += results_due.size();
    end

    $display("Covered %0d requests: %0d inserts (%0d dropped when full), %0d pops (%0d on empty).",
             queued, inserts, drops, pops, empty_pops);
    $display("Checked %0d results over %0d order writes; peak occupancy %0d, %0d long stalls.",
             results_checked, order_writes, peak_occ, holds);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/sqi_pkg.sv
hdl/sqi_in_if.sv
hdl/sqi_out_if.sv
hdl/sqi_cell.sv
hdl/sorted_insert_queue.sv
tb/sorted_insert_queue_tb.sv
